/* rtl/bqf_pkg.sv */
// Shared constants and types for the multichannel biquad filter.
package bqf_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = 4;
  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 32;
  localparam int COEF_FRAC    = COEF_W - 4;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int ACC_W        = PROD_W + 4;
  localparam int SHIFT_W      = ACC_W - COEF_FRAC;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = COEF_W;
  localparam int TERM_W       = 3;
  localparam int HIST_W       = 4 * SAMPLE_W;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_FF0    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FF1    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FF2    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FB1    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FB2    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CHCNT  = 3'd6;

  // Term slots of the shared multiply-accumulate
  localparam logic [TERM_W-1:0] TERM_X0 = 3'd0;
  localparam logic [TERM_W-1:0] TERM_X1 = 3'd1;
  localparam logic [TERM_W-1:0] TERM_X2 = 3'd2;
  localparam logic [TERM_W-1:0] TERM_Y1 = 3'd3;
  localparam logic [TERM_W-1:0] TERM_Y2 = 3'd4;

  // One history entry per channel
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

  // Control from the sequencer to the MAC
  typedef struct packed {
    logic clr;   // load accumulator with the rounding offset
    logic mul;   // register a new product
    logic sub;   // product is subtracted
  } mac_ctrl_t;

endpackage

/* rtl/bqf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module bqf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bqf_mac.sv */
// Shared multiply-accumulate: registered product, then accumulate.
module bqf_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bqf_pkg::mac_ctrl_t                      ctrl,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0]     op_a,
  input  logic signed [bqf_pkg::COEF_W-1:0]       op_b,
  output logic signed [bqf_pkg::ACC_W-1:0]        acc
);
  import bqf_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_OFS = ACC_W'(1) <<< (COEF_FRAC - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic                     sub_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= op_a * op_b;
      sub_r  <= ctrl.sub;
    end
    if (ctrl.clr) begin
      acc_r <= ROUND_OFS;
    end else if (prod_v_r) begin
      acc_r <= sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/multichannel_biquad_filter_core.sv */
// Top level: multichannel direct form I biquad with shared MAC and history RAM.
// Path: a filtered sample goes from the input buffer through the first product,
//   four more products, drain, and shift-saturate into the output register;
//   a passed-through sample goes from the input buffer to the output register.
// Throughput is set by the single MAC (five products) plus the history read
//   and write-back; both paths wait for a free output register before loading it.
// A new sample is buffered while the previous one is still in the MAC.
// Reset (rst_n, synchronous, active low) restores register defaults and marks
//   all history entries invalid (read as zero); a channel count write does too.
module multichannel_biquad_filter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bqf_pkg::SAMPLE_W-1:0]   out_sample_out,
  output logic [bqf_pkg::CH_W-1:0]              out_channel,
  output logic                                  out_clipped,
  input  logic                                  cfg_we,
  input  logic [bqf_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [bqf_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import bqf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_LAST,
    ST_FIN
  } state_t;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic signed [COEF_W-1:0] ff0_r, ff1_r, ff2_r, fb1_r, fb2_r;
  logic                     enable_r;
  logic [CNT_W-1:0]         chcnt_r;
  logic                     chcnt_wr;

  assign chcnt_wr = cfg_we && (cfg_addr == REG_CHCNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff0_r    <= COEF_W'(1) << COEF_FRAC;
      ff1_r    <= '0;
      ff2_r    <= '0;
      fb1_r    <= '0;
      fb2_r    <= '0;
      enable_r <= 1'b1;
      chcnt_r  <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FF0:    ff0_r    <= cfg_data[COEF_W-1:0];
        REG_FF1:    ff1_r    <= cfg_data[COEF_W-1:0];
        REG_FF2:    ff2_r    <= cfg_data[COEF_W-1:0];
        REG_FB1:    fb1_r    <= cfg_data[COEF_W-1:0];
        REG_FB2:    fb2_r    <= cfg_data[COEF_W-1:0];
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_CHCNT:  chcnt_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Channel rotation: zero count means one, oversize clamps to max
  // ---------------------------------------------------------------
  logic [CNT_W-1:0] n_act;
  logic [CH_W-1:0]  ch_r;
  logic [CH_W-1:0]  ch_sel;
  logic [CNT_W-1:0] ch_inc;
  logic [CH_W-1:0]  ch_nxt;

  always_comb begin
    if (chcnt_r == '0) begin
      n_act = CNT_W'(1);
    end else if (chcnt_r > CNT_W'(MAX_CHANNELS)) begin
      n_act = CNT_W'(MAX_CHANNELS);
    end else begin
      n_act = chcnt_r;
    end
    ch_sel = (CNT_W'(ch_r) >= n_act) ? '0 : ch_r;
    ch_inc = CNT_W'(ch_sel) + CNT_W'(1);
    ch_nxt = (ch_inc >= n_act) ? '0 : ch_inc[CH_W-1:0];
  end

  // ---------------------------------------------------------------
  // Input buffer: frees the port while the MAC is busy
  // ---------------------------------------------------------------
  logic                       inbuf_v_r;
  logic signed [SAMPLE_W-1:0] inbuf_r;

  assign in_ready = !inbuf_v_r;

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  state_t                     state_r;
  logic [TERM_W-1:0]          k_r;
  logic [CH_W-1:0]            ch_cur_r;
  logic signed [SAMPLE_W-1:0] x0_r;
  logic [MAX_CHANNELS-1:0]    hvalid_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [CH_W-1:0]            out_ch_r;
  logic                       out_clip_r;

  logic out_free;
  logic take;
  logic fin_go;
  logic out_load;

  assign out_free = !out_valid_r || out_ready;
  // pass-through samples go straight to the output register
  assign take     = (state_r == ST_IDLE) && inbuf_v_r && (enable_r || out_free);
  assign fin_go   = (state_r == ST_FIN) && out_free;
  // a new result loads the output register; otherwise a transfer empties it
  assign out_load = fin_go || (take && !enable_r);

  // History RAM: one packed entry per channel
  logic              ram_we;
  logic              ram_re;
  logic [HIST_W-1:0] ram_rdata;
  hist_t             hist;
  hist_t             hist_wb;

  assign ram_re = take && enable_r;
  assign hist   = hvalid_r[ch_cur_r] ? hist_t'(ram_rdata) : '0;

  // Shared MAC
  mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [COEF_W-1:0]   op_b;
  logic signed [ACC_W-1:0]    acc;

  always_comb begin
    mac_ctrl.clr = ram_re;
    mac_ctrl.mul = ram_re || (state_r == ST_MUL);
    mac_ctrl.sub = (k_r == TERM_Y1) || (k_r == TERM_Y2);
    case (k_r)
      TERM_X0: begin op_a = inbuf_r; op_b = ff0_r; end
      TERM_X1: begin op_a = hist.x1; op_b = ff1_r; end
      TERM_X2: begin op_a = hist.x2; op_b = ff2_r; end
      TERM_Y1: begin op_a = hist.y1; op_b = fb1_r; end
      TERM_Y2: begin op_a = hist.y2; op_b = fb2_r; end
      default: begin op_a = '0;      op_b = '0;    end
    endcase
  end

  bqf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // Round already folded in at clear; floor shift is a bit select
  logic signed [SHIFT_W-1:0]  acc_sh;
  logic [SHIFT_W-SAMPLE_W:0]  acc_top;
  logic                       sat_hi;
  logic                       sat_lo;
  logic signed [SAMPLE_W-1:0] y0;

  always_comb begin
    acc_sh  = acc[ACC_W-1:COEF_FRAC];
    acc_top = acc_sh[SHIFT_W-1:SAMPLE_W-1];
    sat_hi  = !acc_sh[SHIFT_W-1] && (|acc_top);
    sat_lo  = acc_sh[SHIFT_W-1] && !(&acc_top);
    if (sat_hi) begin
      y0 = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      y0 = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y0 = acc_sh[SAMPLE_W-1:0];
    end
    hist_wb.x1 = x0_r;
    hist_wb.x2 = hist.x1;
    hist_wb.y1 = y0;
    hist_wb.y2 = hist.y1;
  end

  assign ram_we = fin_go;

  bqf_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_cur_r),
    .wdata (hist_wb),
    .re    (ram_re),
    .raddr (ch_sel),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= TERM_X0;
      ch_r        <= '0;
      hvalid_r    <= '0;
      inbuf_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // input buffer
      if (in_valid && in_ready) begin
        inbuf_v_r <= 1'b1;
        inbuf_r   <= in_sample_in;
      end else if (take) begin
        inbuf_v_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (take) begin
            ch_cur_r <= ch_sel;
            ch_r     <= ch_nxt;
            x0_r     <= inbuf_r;
            if (enable_r) begin
              k_r     <= TERM_X1;
              state_r <= ST_MUL;
            end else begin
              out_sample_r <= inbuf_r;
              out_ch_r     <= ch_sel;
              out_clip_r   <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          if (k_r == TERM_Y2) begin
            state_r <= ST_LAST;
          end else begin
            k_r <= k_r + TERM_W'(1);
          end
        end
        ST_LAST: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_sample_r          <= y0;
            out_ch_r              <= ch_cur_r;
            out_clip_r            <= sat_hi || sat_lo;
            hvalid_r[ch_cur_r]    <= 1'b1;
            k_r                   <= TERM_X0;
            state_r               <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // channel count write wipes history and the rotation
      if (chcnt_wr) begin
        hvalid_r <= '0;
        ch_r     <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_channel    = out_ch_r;
  assign out_clipped    = out_clip_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  // read and write-back of history never overlap, so no forwarding is needed
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("history read and write in the same cycle");

  // history is read only when a sample starts
  a_read_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (state_r == ST_IDLE))
    else $error("history read outside sample start");

  // a finished sample always lands in the output register
  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished sample not presented");

  // channel pointer stays inside the active channel count
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(ch_r) < n_act) || $past(cfg_we))
    else $error("channel counter out of range");

  // MAC term counter walks only the history terms while multiplying
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> ((k_r != TERM_X0) && (k_r <= TERM_Y2)))
    else $error("MAC term index out of range");

endmodule
